### design/etl_pkg.sv
`timescale 1ns / 1ps

package etl_pkg;

	// lexer states, encoded as in the behavioral definition
	typedef enum logic [3:0] {
		LX_IDLE = 4'd0,
		LX_NUM  = 4'd1,
		LX_ERR  = 4'd2,
		LX_S    = 4'd3,
		LX_SI   = 4'd4,
		LX_SQ   = 4'd5,
		LX_SQR  = 4'd6,
		LX_C    = 4'd7,
		LX_CO   = 4'd8,
		LX_CT   = 4'd9,
		LX_T    = 4'd10,
		LX_TA   = 4'd11,
		LX_L    = 4'd12
	} lex_state_t;

	typedef enum logic [4:0] {
		TK_PLUS    = 5'd0,
		TK_MINUS   = 5'd1,
		TK_DIV     = 5'd2,
		TK_MUL     = 5'd3,
		TK_LPAR    = 5'd4,
		TK_RPAR    = 5'd5,
		TK_X       = 5'd6,
		TK_UNARY   = 5'd7,
		TK_SIN     = 5'd8,
		TK_COS     = 5'd9,
		TK_TAN     = 5'd10,
		TK_CTG     = 5'd11,
		TK_SQRT    = 5'd12,
		TK_LN      = 5'd13,
		TK_NUMCHAR = 5'd14,
		TK_NUMEND  = 5'd15,
		TK_ERROR   = 5'd16
	} token_t;

	// ascii codes
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_A     = 8'h61;
	localparam logic [7:0] CH_C     = 8'h63;
	localparam logic [7:0] CH_G     = 8'h67;
	localparam logic [7:0] CH_I     = 8'h69;
	localparam logic [7:0] CH_L     = 8'h6C;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_O     = 8'h6F;
	localparam logic [7:0] CH_Q     = 8'h71;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_S     = 8'h73;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_X     = 8'h78;

	typedef struct packed {
		token_t     kind;
		logic [7:0] ch;
		logic       last;
	} res_t;

	// everything one character step produces
	typedef struct packed {
		logic [1:0] num;
		res_t       r0;
		res_t       r1;
		lex_state_t lex_nxt;
		logic       point_nxt;
		logic       unary_nxt;
	} step_t;

endpackage

### design/etl_step.sv
`timescale 1ns / 1ps

module etl_step (
	input  logic [7:0]          char_code,
	input  logic                end_of_line,
	input  etl_pkg::lex_state_t lex_state,
	input  logic                point_seen,
	input  logic                unary_allowed,
	output etl_pkg::step_t      step
);
	import etl_pkg::*;

	typedef struct packed {
		logic       emit;
		token_t     kind;
		logic [7:0] ch;
		lex_state_t lex_nxt;
		logic       point_clr;
		logic       unary_nxt;
	} start_t;

	function automatic logic is_numeral(input logic [7:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	// a character with no token open
	function automatic start_t start_char(input logic [7:0] c, input logic unary);
		start_t r;
		r.emit      = 1'b1;
		r.kind      = TK_ERROR;
		r.ch        = 8'd0;
		r.lex_nxt   = LX_IDLE;
		r.point_clr = 1'b0;
		r.unary_nxt = 1'b0;
		case (c)
			CH_SPACE: begin
				r.emit      = 1'b0;
				r.unary_nxt = unary;
			end
			CH_PLUS:  r.kind = TK_PLUS;
			CH_MINUS: r.kind = unary ? TK_UNARY : TK_MINUS;
			CH_SLASH: r.kind = TK_DIV;
			CH_STAR:  r.kind = TK_MUL;
			CH_LPAR: begin
				r.kind      = TK_LPAR;
				r.unary_nxt = 1'b1;
			end
			CH_RPAR:  r.kind = TK_RPAR;
			CH_X:     r.kind = TK_X;
			CH_S, CH_C, CH_T, CH_L: begin
				r.emit      = 1'b0;
				r.unary_nxt = unary;
				r.lex_nxt   = (c == CH_S) ? LX_S : (c == CH_C) ? LX_C :
				              (c == CH_T) ? LX_T : LX_L;
			end
			default: begin
				r.unary_nxt = unary;
				if (is_numeral(c)) begin
					r.kind      = TK_NUMCHAR;
					r.ch        = c;
					r.point_clr = 1'b1;
					r.lex_nxt   = LX_NUM;
				end else begin
					r.lex_nxt = LX_ERR;
				end
			end
		endcase
		return r;
	endfunction

	start_t st;
	start_t st_num;
	token_t kw_tok;
	logic   kw_done;
	logic   kw_adv;
	lex_state_t kw_nxt;
	logic   in_keyword;

	assign in_keyword = (lex_state != LX_IDLE) && (lex_state != LX_NUM) && (lex_state != LX_ERR);
	assign st     = start_char(char_code, unary_allowed);
	assign st_num = start_char(char_code, 1'b0);

	// keyword prefix continuation
	always_comb begin
		kw_tok  = TK_ERROR;
		kw_done = 1'b0;
		kw_adv  = 1'b0;
		kw_nxt  = LX_ERR;
		case (lex_state)
			LX_S: begin
				if (char_code == CH_I) begin
					kw_adv = 1'b1;
					kw_nxt = LX_SI;
				end else if (char_code == CH_Q) begin
					kw_adv = 1'b1;
					kw_nxt = LX_SQ;
				end
			end
			LX_SI:  if (char_code == CH_N) begin kw_done = 1'b1; kw_tok = TK_SIN; end
			LX_SQ: begin
				if (char_code == CH_R) begin
					kw_adv = 1'b1;
					kw_nxt = LX_SQR;
				end
			end
			LX_SQR: if (char_code == CH_T) begin kw_done = 1'b1; kw_tok = TK_SQRT; end
			LX_C: begin
				if (char_code == CH_O) begin
					kw_adv = 1'b1;
					kw_nxt = LX_CO;
				end else if (char_code == CH_T) begin
					kw_adv = 1'b1;
					kw_nxt = LX_CT;
				end
			end
			LX_CO:  if (char_code == CH_S) begin kw_done = 1'b1; kw_tok = TK_COS; end
			LX_CT:  if (char_code == CH_G) begin kw_done = 1'b1; kw_tok = TK_CTG; end
			LX_T: begin
				if (char_code == CH_A) begin
					kw_adv = 1'b1;
					kw_nxt = LX_TA;
				end
			end
			LX_TA:  if (char_code == CH_N) begin kw_done = 1'b1; kw_tok = TK_TAN; end
			LX_L:   if (char_code == CH_N) begin kw_done = 1'b1; kw_tok = TK_LN; end
			default: ;
		endcase
		if (kw_done)
			kw_nxt = LX_IDLE;
	end

	always_comb begin
		step.num       = 2'd0;
		step.r0        = '{kind: TK_ERROR, ch: 8'd0, last: 1'b0};
		step.r1        = '{kind: TK_ERROR, ch: 8'd0, last: 1'b1};
		step.lex_nxt   = lex_state;
		step.point_nxt = point_seen;
		step.unary_nxt = unary_allowed;
		if (end_of_line) begin
			if (lex_state == LX_NUM) begin
				step.num     = 2'd1;
				step.r0.kind = TK_NUMEND;
			end else if (in_keyword) begin
				step.num = 2'd1;
			end
			step.lex_nxt   = LX_IDLE;
			step.point_nxt = 1'b0;
			step.unary_nxt = 1'b1;
		end else if (lex_state == LX_ERR) begin
			// sticky until end of line
		end else if (lex_state == LX_NUM) begin
			if (is_numeral(char_code)) begin
				step.num     = 2'd1;
				step.r0.kind = TK_NUMCHAR;
				step.r0.ch   = char_code;
			end else if (char_code == CH_POINT) begin
				step.num = 2'd1;
				if (point_seen) begin
					step.lex_nxt = LX_ERR;
				end else begin
					step.point_nxt = 1'b1;
					step.r0.kind   = TK_NUMCHAR;
					step.r0.ch     = char_code;
				end
			end else begin
				// number ends, then the character starts afresh
				step.r0.kind   = TK_NUMEND;
				step.num       = st_num.emit ? 2'd2 : 2'd1;
				step.r1.kind   = st_num.kind;
				step.r1.ch     = st_num.ch;
				step.lex_nxt   = st_num.lex_nxt;
				step.point_nxt = 1'b0;
				step.unary_nxt = st_num.unary_nxt;
			end
		end else if (in_keyword) begin
			step.num = kw_done ? 2'd1 : (kw_adv ? 2'd0 : 2'd1);
			step.r0.kind = kw_tok;
			step.lex_nxt = kw_nxt;
			if (kw_done)
				step.unary_nxt = 1'b0;
		end else begin
			step.num       = st.emit ? 2'd1 : 2'd0;
			step.r0.kind   = st.kind;
			step.r0.ch     = st.ch;
			step.lex_nxt   = st.lex_nxt;
			step.unary_nxt = st.unary_nxt;
			if (st.point_clr)
				step.point_nxt = 1'b0;
		end
		step.r0.last = (step.num == 2'd1);
	end

endmodule

### design/expression_token_lexer_core.sv
`timescale 1ns / 1ps

// streaming lexer for arithmetic expressions: one ascii character (or an end-of-line
// mark) per input request, zero, one or two token requests out per character. a
// character is held in an input register, its tokens are worked out combinationally
// and pushed into a four-entry result queue that drives the output ports. a new
// character is taken every cycle as long as the queue has two free entries, so a
// line lexes at one character per cycle whenever each character gives at most one
// token and the output side keeps up; a character that ends a number and starts
// another token gives two tokens and the output then paces the stream at one token
// per cycle. a character's tokens go from the input register into the result
// queue and out from there; the character waits in the input register while the
// queue lacks two free entries. number digits come out one per token kind numchar
// with the character on number_char, closed by numend; last_result marks the final
// token of a character. after an error the lexer stays silent until end of line.

module expression_token_lexer_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_code,
	input  logic       end_of_line,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [4:0] token_kind,
	output logic [7:0] number_char,
	output logic       last_result
);
	import etl_pkg::*;

	// input register
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       eol_s1;

	// lexer state
	lex_state_t lex_state_q;
	logic       point_seen_q;
	logic       unary_q;

	// result queue
	res_t       queue_q [4];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] count_q;

	step_t step;
	logic  advance;
	logic  pop;
	logic [1:0] wr_ptr_nxt;

	etl_step u_step (
		.char_code     (char_s1),
		.end_of_line   (eol_s1),
		.lex_state     (lex_state_q),
		.point_seen    (point_seen_q),
		.unary_allowed (unary_q),
		.step          (step)
	);

	// the held character moves on only when the queue can take both tokens
	assign advance  = valid_s1 && (count_q <= 3'd2);
	assign in_ready = !valid_s1 || advance;
	assign pop      = out_valid && out_ready;
	assign wr_ptr_nxt = wr_ptr_q + 2'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_code;
			eol_s1  <= end_of_line;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lex_state_q  <= LX_IDLE;
			point_seen_q <= 1'b0;
			unary_q      <= 1'b1;
		end else if (advance) begin
			lex_state_q  <= step.lex_nxt;
			point_seen_q <= step.point_nxt;
			unary_q      <= step.unary_nxt;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			count_q  <= 3'd0;
		end else begin
			if (advance)
				wr_ptr_q <= wr_ptr_q + step.num;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 2'd1;
			count_q <= count_q + (advance ? {1'b0, step.num} : 3'd0) - {2'b00, pop};
		end
	end

	// queue storage, up to two writes per cycle
	always_ff @(posedge clk) begin
		if (advance && (step.num != 2'd0))
			queue_q[wr_ptr_q] <= step.r0;
		if (advance && (step.num == 2'd2))
			queue_q[wr_ptr_nxt] <= step.r1;
	end

	assign out_valid   = (count_q != 3'd0);
	assign token_kind  = queue_q[rd_ptr_q].kind;
	assign number_char = queue_q[rd_ptr_q].ch;
	assign last_result = queue_q[rd_ptr_q].last;

endmodule
